// ----- hdl/esd_pkg.sv -----
`default_nettype none

package esd_pkg;

  // Width of the output position counter. It saturates at its all-ones value.
  localparam int unsigned CountBits = 16;
  // Width that holds both the counter and the 16-bit capacity.
  localparam int unsigned WideBits  = (CountBits > 16) ? CountBits : 16;

  // Depth of the run queue between the front and back ends.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrBits = $clog2(QueueDepth);

  // Largest number of bytes that one input byte can produce.
  localparam int unsigned RunMax = 4;

  localparam logic [7:0] CharBslash = 8'h5c;
  localparam logic [7:0] CharX      = 8'h78;
  localparam logic [7:0] CharN      = 8'h6e;
  localparam logic [7:0] CharR      = 8'h72;
  localparam logic [7:0] CharT      = 8'h74;
  localparam logic [7:0] CharE      = 8'h65;
  localparam logic [7:0] CodeLf     = 8'h0a;
  localparam logic [7:0] CodeCr     = 8'h0d;
  localparam logic [7:0] CodeTab    = 8'h09;
  localparam logic [7:0] CodeEsc    = 8'h1b;

  // One decoded run: the bytes caused by one input byte.
  typedef struct packed {
    logic [RunMax-1:0][7:0] bytes;
    logic [2:0]             cnt;
    logic                   last;
  } run_t;

endpackage

`default_nettype wire

// ----- hdl/esd_front.sv -----
`default_nettype none

module esd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          in_last_i,
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output esd_pkg::run_t      q_run_o
);

  typedef enum logic [3:0] {
    ModePlain  = 4'b0001,
    ModeBslash = 4'b0010,
    ModeHex1   = 4'b0100,
    ModeHex2   = 4'b1000
  } mode_e;

  mode_e      mode_q, mode_d;
  logic [7:0] held_q, held_d;
  logic       accept;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] esc_val(input logic [7:0] c);
    logic [7:0] v;
    case (c)
      esd_pkg::CharN: v = esd_pkg::CodeLf;
      esd_pkg::CharR: v = esd_pkg::CodeCr;
      esd_pkg::CharT: v = esd_pkg::CodeTab;
      esd_pkg::CharE: v = esd_pkg::CodeEsc;
      default:        v = c;
    endcase
    return v;
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    esd_pkg::run_t run;
    logic          tail;
    run      = '0;
    tail     = 1'b0;
    mode_d   = mode_q;
    held_d   = held_q;
    run.last = in_last_i;

    unique case (mode_q)
      ModePlain: begin
        tail = 1'b1;
      end
      ModeBslash: begin
        mode_d = ModePlain;
        if (in_byte_i == esd_pkg::CharX) begin
          if (!in_last_i) begin
            mode_d = ModeHex1;
          end else begin
            run.bytes[0] = esd_pkg::CharBslash;
            run.bytes[1] = esd_pkg::CharX;
            run.cnt      = 3'd2;
          end
        end else begin
          run.bytes[0] = esc_val(in_byte_i);
          run.cnt      = 3'd1;
        end
      end
      ModeHex1: begin
        if (!in_last_i && is_hex(in_byte_i)) begin
          held_d = in_byte_i;
          mode_d = ModeHex2;
        end else begin
          run.bytes[0] = esd_pkg::CharBslash;
          run.bytes[1] = esd_pkg::CharX;
          run.cnt      = 3'd2;
          tail         = 1'b1;
        end
      end
      ModeHex2: begin
        // The held character was checked as a hex digit when it was taken.
        if (is_hex(in_byte_i)) begin
          run.bytes[0] = {hex_val(held_q), hex_val(in_byte_i)};
          run.cnt      = 3'd1;
          mode_d       = ModePlain;
        end else begin
          run.bytes[0] = esd_pkg::CharBslash;
          run.bytes[1] = esd_pkg::CharX;
          run.bytes[2] = held_q;
          run.cnt      = 3'd3;
          tail         = 1'b1;
        end
      end
      default: begin
        mode_d = ModePlain;
      end
    endcase

    // Plain text decode; a backslash not ending the text opens an escape.
    if (tail) begin
      if ((in_byte_i == esd_pkg::CharBslash) && !in_last_i) begin
        mode_d = ModeBslash;
      end else begin
        mode_d                 = ModePlain;
        run.bytes[run.cnt[1:0]] = in_byte_i;
        run.cnt                = run.cnt + 3'd1;
      end
    end

    if (in_last_i) begin
      mode_d = ModePlain;
      held_d = '0;
    end

    q_run_o  = run;
    // A run without bytes still travels when it ends the text, so the
    // back end can clear its position counter.
    q_push_o = accept && ((run.cnt != 3'd0) || in_last_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModePlain;
      held_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/esd_queue.sv -----
`default_nettype none

module esd_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire esd_pkg::run_t push_run_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output esd_pkg::run_t      head_o,
  output logic               empty_o
);

  localparam int unsigned PtrBits = esd_pkg::QueuePtrBits;
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(esd_pkg::QueueDepth - 1);

  esd_pkg::run_t        entry_q [esd_pkg::QueueDepth];
  logic [PtrBits-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrBits:0]     fill_q;

  assign full_o  = (fill_q == (PtrBits + 1)'(esd_pkg::QueueDepth));
  assign empty_o = (fill_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_run_i;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("run queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("run queue read while empty");
`endif

endmodule

`default_nettype wire

// ----- hdl/esd_back.sv -----
`default_nettype none

module esd_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [15:0]   cfg_wdata_i,
  input  wire esd_pkg::run_t head_i,
  input  wire logic          empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic [15:0]        position_o,
  output logic               in_capacity_o,
  output logic               run_last_o,
  output logic               text_last_o
);

  localparam int unsigned CountBits = esd_pkg::CountBits;
  localparam int unsigned WideBits  = esd_pkg::WideBits;
  localparam logic [CountBits-1:0] CountMax = '1;
  localparam logic [WideBits-1:0]  PosMax   = WideBits'(16'hffff);

  logic [15:0]           capacity_q;
  logic [CountBits-1:0]  count_q;
  logic [1:0]            idx_q;
  logic                  valid_q;
  logic [7:0]            byte_q;
  logic [15:0]           pos_q;
  logic                  cap_q, run_last_q, text_last_q;

  logic                  out_free, step, zero_run, run_end, emit;
  logic [WideBits-1:0]   count_wide;

  always_comb begin
    out_free   = !valid_q || out_ready_i;
    step       = !empty_i && out_free;
    zero_run   = (head_i.cnt == 3'd0);
    run_end    = zero_run || (({1'b0, idx_q} + 3'd1) == head_i.cnt);
    pop_o      = step && run_end;
    emit       = step && !zero_run;
    count_wide = WideBits'(count_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= 16'd32;
      count_q    <= '0;
      idx_q      <= '0;
      valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      if (pop_o && head_i.last) begin
        count_q <= '0;
      end else if (emit && (count_q != CountMax)) begin
        count_q <= count_q + 1'b1;
      end
      if (pop_o) begin
        idx_q <= '0;
      end else if (emit) begin
        idx_q <= idx_q + 2'd1;
      end
      if (emit) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q      <= head_i.bytes[idx_q];
      pos_q       <= (count_wide > PosMax) ? 16'hffff : count_wide[15:0];
      cap_q       <= count_wide < WideBits'(capacity_q);
      run_last_q  <= run_end;
      text_last_q <= run_end && head_i.last;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_byte_o    = byte_q;
  assign position_o    = pos_q;
  assign in_capacity_o = cap_q;
  assign run_last_o    = run_last_q;
  assign text_last_o   = text_last_q;

`ifndef SYNTH
  a_text_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && text_last_q) |-> run_last_q)
    else $error("text end flagged on a byte that does not end its run");
  a_count_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && head_i.last) |=> (count_q == '0))
    else $error("position counter not cleared after end of text");
`endif

endmodule

`default_nettype wire

// ----- hdl/escape_sequence_decoder.sv -----
// Channel   Dir  Payload                                       Accepted when
// s_axis    in   tdata[7:0] in_byte, tlast end_of_text         tvalid & tready
// m_axis    out  tdata out_byte/position, tuser flags, tlast   tvalid & tready
// cfg       in   cfg_wdata_i capacity                          cfg_we_i
//
// One input byte can be taken every cycle; the back end sends one decoded byte
// per cycle while the output is ready, so an input that expands to several
// bytes holds the input side only once the four-entry run queue between the
// two ends is full; decoded runs pass the run queue, then the output register.
// Reset is asynchronous and active low; capacity returns to 32.
// A stalled output keeps its byte in the output register while input continues.
`default_nettype none

module escape_sequence_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,     // capacity
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // [7:0] in_byte
  input  wire logic        s_axis_tlast_i,  // end_of_text
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,  // [7:0] out_byte, [23:8] position
  output logic [1:0]       m_axis_tuser_o,  // [0] in_capacity, [1] run_last
  output logic             m_axis_tlast_o   // text_last
);

  esd_pkg::run_t push_run, head_run;
  logic          push, pop, full, empty;
  logic [7:0]    out_byte;
  logic [15:0]   position;
  logic          in_cap, run_last, text_last;

  esd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_run_o    (push_run)
  );

  esd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_run_i (push_run),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head_run),
    .empty_o    (empty)
  );

  esd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .head_i        (head_run),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_byte_o    (out_byte),
    .position_o    (position),
    .in_capacity_o (in_cap),
    .run_last_o    (run_last),
    .text_last_o   (text_last)
  );

  assign m_axis_tdata_o = {position, out_byte};
  assign m_axis_tuser_o = {run_last, in_cap};
  assign m_axis_tlast_o = text_last;

endmodule

`default_nettype wire

// ----- tb/sv/esd_decode_checker.sv -----
module esd_decode_checker
  import esd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [23:0] out_data_i,
  input  logic [1:0]  out_user_i,
  input  logic        out_last_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0]         ResetCapacity = 16'd32;
  localparam logic [WideBits-1:0] CountMax      = WideBits'({CountBits{1'b1}});

  typedef enum logic [1:0] {
    EscPlain,
    EscBackslash,
    EscHex1,
    EscHex2
  } esc_mode_e;

  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] pos;
    logic        fits;
    logic        run_end;
    logic        text_end;
  } dec_byte_t;

  // Predicted decoder state.
  logic [15:0]         capacity = ResetCapacity;
  esc_mode_e           mode     = EscPlain;
  logic [7:0]          held_hex = '0;
  logic [WideBits-1:0] out_count = '0;

  dec_byte_t run_buf [RunMax];
  int        run_len;
  dec_byte_t expected_bytes [$];
  int        fails = 0;

  assign fail_count_o = fails;

  function automatic bit is_hex(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_nibble(logic [7:0] c);
    logic [7:0] v;
    if (c <= "9") v = c - "0";
    else if (c >= "a") v = c - "a" + 8'd10;
    else v = c - "A" + 8'd10;
    return v[3:0];
  endfunction

  function automatic logic [7:0] escaped_char(logic [7:0] c);
    case (c)
      CharN: return CodeLf;
      CharR: return CodeCr;
      CharT: return CodeTab;
      CharE: return CodeEsc;
      default: return c;
    endcase
  endfunction

  task automatic emit_byte(logic [7:0] b);
    if (run_len < RunMax) begin
      run_buf[run_len].data     = b;
      run_buf[run_len].pos      = (out_count > WideBits'(16'hFFFF)) ? 16'hFFFF : out_count[15:0];
      run_buf[run_len].fits     = out_count < WideBits'(capacity);
      run_buf[run_len].run_end  = 1'b0;
      run_buf[run_len].text_end = 1'b0;
      run_len++;
      if (out_count < CountMax) out_count++;
    end
  endtask

  task automatic take_plain(logic [7:0] b, logic eot);
    if (b == CharBslash && !eot) begin
      mode = EscBackslash;
    end else begin
      mode = EscPlain;
      emit_byte(b);
    end
  endtask

  task automatic decode_step(logic [7:0] b, logic eot);
    run_len = 0;
    case (mode)
      EscPlain: take_plain(b, eot);
      EscBackslash: begin
        if (b == CharX && !eot) begin
          mode = EscHex1;
        end else if (b == CharX) begin
          mode = EscPlain;
          emit_byte(CharBslash);
          emit_byte(CharX);
        end else begin
          mode = EscPlain;
          emit_byte(escaped_char(b));
        end
      end
      EscHex1: begin
        if (!eot && is_hex(b)) begin
          held_hex = b;
          mode = EscHex2;
        end else begin
          emit_byte(CharBslash);
          emit_byte(CharX);
          take_plain(b, eot);
        end
      end
      default: begin
        if (is_hex(held_hex) && is_hex(b)) begin
          mode = EscPlain;
          emit_byte({hex_nibble(held_hex), hex_nibble(b)});
        end else begin
          // A broken hex escape is replayed and the current byte decoded afresh.
          emit_byte(CharBslash);
          emit_byte(CharX);
          emit_byte(held_hex);
          take_plain(b, eot);
        end
      end
    endcase
    if (run_len > 0) begin
      run_buf[run_len-1].run_end  = 1'b1;
      run_buf[run_len-1].text_end = eot;
    end
    for (int i = 0; i < run_len; i++) expected_bytes.push_back(run_buf[i]);
    if (eot) begin
      mode      = EscPlain;
      held_hex  = '0;
      out_count = '0;
    end
  endtask

  task automatic report(string field, int unsigned got, int unsigned want);
    fails++;
    $display("[%0t] %s mismatch: got 0x%0h, expected 0x%0h", $time, field, got, want);
  endtask

  task automatic check_output();
    dec_byte_t want;
    if (expected_bytes.size() == 0) begin
      report("unexpected output transfer", out_data_i, 0);
    end else begin
      want = expected_bytes.pop_front();
      if (out_data_i[7:0] != want.data) report("out_byte", out_data_i[7:0], want.data);
      if (out_data_i[23:8] != want.pos) report("position", out_data_i[23:8], want.pos);
      if (out_user_i[0] != want.fits) report("in_capacity", out_user_i[0], want.fits);
      if (out_user_i[1] != want.run_end) report("run_last", out_user_i[1], want.run_end);
      if (out_last_i != want.text_end) report("text_last", out_last_i, want.text_end);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity  = ResetCapacity;
      mode      = EscPlain;
      held_hex  = '0;
      out_count = '0;
      expected_bytes.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) capacity = cfg_wdata_i;
      // An output transfer never stems from an input taken at the same edge.
      if (out_valid_i && out_ready_i) check_output();
      if (in_valid_i && in_ready_i) decode_step(in_byte_i, in_last_i);
      pending_o = expected_bytes.size();
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
  import esd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit   = 2000;
  localparam int PhaseItems   = 80;
  localparam int DrainCycles  = 10;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_valid   = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data    = '0;
  logic        s_last    = 1'b0;
  logic        m_valid;
  logic        m_ready   = 1'b0;
  logic [23:0] m_data;
  logic [1:0]  m_user;
  logic        m_last;

  int fail_count;
  int pending;
  int quiet_cycles = 0;
  int stall_left   = 0;
  bit idle_on      = 1'b1;

  logic [7:0] text_q [$];

  escape_sequence_decoder u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  esd_decode_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (s_valid),
    .in_ready_i   (s_ready),
    .in_byte_i    (s_data),
    .in_last_i    (s_last),
    .out_valid_i  (m_valid),
    .out_ready_i  (m_ready),
    .out_data_i   (m_data),
    .out_user_i   (m_user),
    .out_last_i   (m_last),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Output side back-pressure in short random bursts while idling is on.
  always @(negedge clk) begin
    if (!idle_on) begin
      m_ready <= 1'b1;
    end else if (stall_left > 0) begin
      m_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      m_ready <= 1'b0;
      stall_left = $urandom_range(0, 4);
    end else begin
      m_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WatchLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= eot;
    do @(posedge clk); while (!s_ready);
    @(negedge clk);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // Called at a falling edge; holds the sender off until all output has drained.
  task automatic wait_drained();
    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] hex_char();
    logic [3:0] v;
    v = 4'($urandom_range(0, 15));
    if (v < 4'd10) return "0" + v;
    return 8'(($urandom_range(0, 1) ? "A" : "a") + v - 10);
  endfunction

  function automatic logic [7:0] named_char();
    case ($urandom_range(0, 3))
      0: return CharN;
      1: return CharR;
      2: return CharT;
      default: return CharE;
    endcase
  endfunction

  // Random plain bytes and escapes, most of them well-formed, plus some noise.
  task automatic build_text();
    int tokens;
    text_q.delete();
    tokens = $urandom_range(1, 6);
    repeat (tokens) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: text_q.push_back(8'($urandom_range(1, 255)));
        4: begin
          text_q.push_back(CharBslash);
          text_q.push_back(named_char());
        end
        5: begin
          text_q.push_back(CharBslash);
          text_q.push_back(8'($urandom_range(1, 255)));
        end
        6, 7: begin
          text_q.push_back(CharBslash);
          text_q.push_back(CharX);
          text_q.push_back(hex_char());
          text_q.push_back(hex_char());
        end
        8: begin
          text_q.push_back(CharBslash);
          text_q.push_back(CharX);
          if ($urandom_range(0, 1)) text_q.push_back(hex_char());
          text_q.push_back(8'($urandom_range(1, 255)));
        end
        default: text_q.push_back(CharBslash);
      endcase
    end
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  initial begin
    int sent;
    logic [15:0] phase_cap;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed texts at the reset capacity.
    send_byte(8'h01, 1'b0);
    send_str("\\n\\r\\t\\e");
    send_str("\\x4f\\xEz");
    send_str("\\xg\\x\\q\\");
    send_str("\\x5");
    send_str("\\x");
    send_byte(8'hFF, 1'b1);

    for (int p = 0; p < 5; p++) begin
      wait_drained();
      case (p)
        0: phase_cap = 16'd0;
        1: phase_cap = 16'hFFFF;
        2: phase_cap = 16'd1;
        3: phase_cap = 16'($urandom_range(2, 12));
        default: phase_cap = 16'($urandom);
      endcase
      write_capacity(phase_cap);
      idle_on = (p == 2) ? 1'b0 : 1'b1;
      sent = 0;
      while (sent < PhaseItems) begin
        build_text();
        send_text();
        sent += text_q.size();
      end
    end

    // Last part: no idling on either side.
    wait_drained();
    idle_on = 1'b0;
    write_capacity(16'($urandom_range(2, 12)));
    repeat (5) begin
      build_text();
      send_text();
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
